// ===== rtl/millisecond_tick_clock_macros.svh =====
// assertion macros for the millisecond tick clock
`ifndef MILLISECOND_TICK_CLOCK_MACROS_SVH
`define MILLISECOND_TICK_CLOCK_MACROS_SVH
`ifndef SYNTHESIS
`define MTC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MTC_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define MTC_ASSERT(lbl, clk, rst, prop, msg)
`define MTC_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// ===== rtl/mtc_pkg.sv =====
// shared types and constants for the millisecond tick clock
package mtc_pkg;

   localparam int OpcodeWidth = 2;
   localparam int ValueWidth  = 16;
   localparam int MsWidth     = 10;
   localparam int SecWidth    = 6;
   localparam int MinWidth    = 6;
   localparam int HourWidth   = 5;
   localparam int PeriodWidth = 8;
   localparam int CsrIdxWidth = 1;
   localparam int CsrDataWidth = 8;

   localparam logic [OpcodeWidth-1:0] OP_TICK       = 2'd0;
   localparam logic [OpcodeWidth-1:0] OP_LOAD_DELAY = 2'd1;
   localparam logic [OpcodeWidth-1:0] OP_LOAD_SEC   = 2'd2;
   localparam logic [OpcodeWidth-1:0] OP_LOAD_MIN   = 2'd3;

   localparam logic [CsrIdxWidth-1:0] CSR_SAMPLE_ENABLE = 1'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_SAMPLE_PERIOD = 1'd1;

   localparam logic [PeriodWidth-1:0] PeriodReset = 8'd4;

   localparam logic [MsWidth-1:0]   MsTop         = 10'd999;
   localparam logic [SecWidth-1:0]  SecTop        = 6'd59;
   localparam logic [MinWidth-1:0]  MinTop        = 6'd59;
   localparam logic [HourWidth-1:0] HourTop       = 5'd23;
   localparam logic [MsWidth-1:0]   BeatFirstEnd  = 10'd200;
   localparam logic [MsWidth-1:0]   BeatSecondEnd = 10'd400;

   typedef struct packed {
      logic [ValueWidth-1:0] tick_total;
      logic [MsWidth-1:0]    millis;
      logic [SecWidth-1:0]   seconds;
      logic [MinWidth-1:0]   minutes;
      logic [HourWidth-1:0]  hours;
      logic [ValueWidth-1:0] delay_left;
      logic [ValueWidth-1:0] sec_left;
      logic [ValueWidth-1:0] min_left;
      logic                  beat_first;
      logic                  beat_second;
   } tod_state_type;

   typedef struct packed {
      logic                   commit;
      logic [OpcodeWidth-1:0] opcode;
      logic [ValueWidth-1:0]  load_value;
   } tod_cmd_type;

endpackage

// ===== rtl/mtc_channels.sv =====
// handshake channel interfaces for the millisecond tick clock
interface mtc_req_if;
   import mtc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [OpcodeWidth-1:0] opcode;
   logic [ValueWidth-1:0]  load_value;
   modport source (output valid, output opcode, output load_value, input ready);
   modport sink (input valid, input opcode, input load_value, output ready);
endinterface

interface mtc_rsp_if;
   import mtc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [ValueWidth-1:0] tick_total;
   logic [MsWidth-1:0]    millis;
   logic [SecWidth-1:0]   seconds;
   logic [MinWidth-1:0]   minutes;
   logic [HourWidth-1:0]  hours;
   logic [ValueWidth-1:0] delay_left;
   logic [ValueWidth-1:0] sec_left;
   logic [ValueWidth-1:0] min_left;
   logic                  beat_first;
   logic                  beat_second;
   logic                  sample_strobe;
   modport source (output valid, output tick_total, output millis, output seconds,
                   output minutes, output hours, output delay_left, output sec_left,
                   output min_left, output beat_first, output beat_second,
                   output sample_strobe, input ready);
   modport sink (input valid, input tick_total, input millis, input seconds,
                 input minutes, input hours, input delay_left, input sec_left,
                 input min_left, input beat_first, input beat_second,
                 input sample_strobe, output ready);
endinterface

interface mtc_csr_if;
   import mtc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CsrIdxWidth-1:0]  index;
   logic [CsrDataWidth-1:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/mtc_mod_unit.sv =====
// bit-serial restoring remainder of the millisecond value by the sample period
module mtc_mod_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [mtc_pkg::MsWidth-1:0]     dividend,
   input  logic [mtc_pkg::PeriodWidth-1:0] divisor,
   output logic                           done,
   output logic                           rem_zero
);
   import mtc_pkg::*;

   localparam int CountWidth = $clog2(MsWidth);
   localparam logic [CountWidth-1:0] LastStep = CountWidth'(MsWidth - 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic [MsWidth-1:0]     shift_ff, shift_in;
   logic [PeriodWidth-1:0] rem_ff, rem_in;
   logic [PeriodWidth-1:0] divisor_ff, divisor_in;
   logic [PeriodWidth:0]   trial;

   // one quotient bit per cycle, msb first
   assign trial = {rem_ff, shift_ff[MsWidth-1]};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         shift_in   = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         shift_in = {shift_ff[MsWidth-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in = PeriodWidth'(trial - {1'b0, divisor_ff});
         end else begin
            rem_in = trial[PeriodWidth-1:0];
         end
         count_in = count_ff + 1'b1;
         if (count_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

// ===== rtl/mtc_tod.sv =====
// time-of-day, down-counter and heartbeat registers with their update logic
`include "millisecond_tick_clock_macros.svh"
module mtc_tod (
   input  logic                   clock,
   input  logic                   reset,
   input  mtc_pkg::tod_cmd_type   cmd,
   output mtc_pkg::tod_state_type state_cur,
   output mtc_pkg::tod_state_type state_next
);
   import mtc_pkg::*;

   tod_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      if (cmd.commit) begin
         unique case (cmd.opcode)
            OP_TICK: begin
               state_in.tick_total = state_ff.tick_total + 1'b1;
               if (state_ff.delay_left != '0) begin
                  state_in.delay_left = state_ff.delay_left - 1'b1;
               end
               // heartbeat from the value before the tick, both off at exactly 200
               state_in.beat_first  = (state_ff.millis < BeatFirstEnd);
               state_in.beat_second = (state_ff.millis > BeatFirstEnd) &&
                                      (state_ff.millis < BeatSecondEnd);
               if (state_ff.millis >= MsTop) begin
                  state_in.millis = '0;
                  if (state_ff.sec_left != '0) begin
                     state_in.sec_left = state_ff.sec_left - 1'b1;
                  end
                  if (state_ff.seconds >= SecTop) begin
                     state_in.seconds = '0;
                     if (state_ff.min_left != '0) begin
                        state_in.min_left = state_ff.min_left - 1'b1;
                     end
                     if (state_ff.minutes >= MinTop) begin
                        state_in.minutes = '0;
                        if (state_ff.hours >= HourTop) begin
                           state_in.hours = '0;
                        end else begin
                           state_in.hours = state_ff.hours + 1'b1;
                        end
                     end else begin
                        state_in.minutes = state_ff.minutes + 1'b1;
                     end
                  end else begin
                     state_in.seconds = state_ff.seconds + 1'b1;
                  end
               end else begin
                  state_in.millis = state_ff.millis + 1'b1;
               end
            end
            OP_LOAD_DELAY: state_in.delay_left = cmd.load_value;
            OP_LOAD_SEC:   state_in.sec_left   = cmd.load_value;
            OP_LOAD_MIN:   state_in.min_left   = cmd.load_value;
            default:       state_in = state_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state_cur  = state_ff;
   assign state_next = state_in;

   `MTC_ASSERT(a_ms_range, clock, reset, state_ff.millis <= MsTop, "millis past top")
   `MTC_ASSERT(a_hour_range, clock, reset, state_ff.hours <= HourTop, "hours past top")
   `MTC_ASSERT(a_load_holds_time, clock, reset, (cmd.commit && cmd.opcode != OP_TICK) |=> $stable(state_ff.millis) && $stable(state_ff.tick_total), "load moved the clock")

endmodule

// ===== rtl/millisecond_tick_clock.sv =====
// tick word: idle, then the remainder state, then the finish state, which commits once the output is free
// load word: idle, then straight to the finish state; a new word is taken only back in idle
// the tick path runs the 10-step bit-serial remainder of millis by the sample period
// a result waits in the output register while the next word is taken
// synchronous active-high reset clears the clock, the counters and the LEDs; period resets to 4
`include "millisecond_tick_clock_macros.svh"
module millisecond_tick_clock (
   input logic      clock,
   input logic      reset,
   mtc_req_if.sink  req_if,
   mtc_rsp_if.source rsp_if,
   mtc_csr_if.sink  csr_if
);
   import mtc_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MOD    = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [OpcodeWidth-1:0] opcode_ff, opcode_in;
   logic [ValueWidth-1:0]  value_ff, value_in;
   logic                   enable_ff;
   logic [PeriodWidth-1:0] period_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   tod_state_type          rsp_data_ff;
   logic                   strobe_ff;

   logic          req_take;
   logic          out_free;
   logic          commit;
   logic          strobe;
   logic          mod_start;
   logic          mod_done;
   logic          rem_zero;
   tod_cmd_type   tod_cmd;
   tod_state_type tod_cur;
   tod_state_type tod_next;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_take     = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign commit       = (state_ff == ST_FINISH) && out_free;
   assign mod_start    = req_take && (req_if.opcode == OP_TICK);
   assign strobe       = (opcode_ff == OP_TICK) && enable_ff && (period_ff != '0) && rem_zero;

   assign tod_cmd.commit     = commit;
   assign tod_cmd.opcode     = opcode_ff;
   assign tod_cmd.load_value = value_ff;

   mtc_mod_unit u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (tod_cur.millis),
      .divisor  (period_ff),
      .done     (mod_done),
      .rem_zero (rem_zero)
   );

   mtc_tod u_tod (
      .clock      (clock),
      .reset      (reset),
      .cmd        (tod_cmd),
      .state_cur  (tod_cur),
      .state_next (tod_next)
   );

   always_comb begin
      state_in  = state_ff;
      opcode_in = opcode_ff;
      value_in  = value_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               opcode_in = req_if.opcode;
               value_in  = req_if.load_value;
               state_in  = (req_if.opcode == OP_TICK) ? ST_MOD : ST_FINISH;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // configuration words land only while idle
   assign csr_if.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         enable_ff    <= 1'b0;
         period_ff    <= PeriodReset;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            unique case (csr_if.index)
               CSR_SAMPLE_ENABLE: enable_ff <= csr_if.wdata[0];
               CSR_SAMPLE_PERIOD: period_ff <= csr_if.wdata[PeriodWidth-1:0];
               default: ;
            endcase
         end
      end
      opcode_ff <= opcode_in;
      value_ff  <= value_in;
      if (commit) begin
         rsp_data_ff <= tod_next;
         strobe_ff   <= strobe;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.tick_total    = rsp_data_ff.tick_total;
   assign rsp_if.millis        = rsp_data_ff.millis;
   assign rsp_if.seconds       = rsp_data_ff.seconds;
   assign rsp_if.minutes       = rsp_data_ff.minutes;
   assign rsp_if.hours         = rsp_data_ff.hours;
   assign rsp_if.delay_left    = rsp_data_ff.delay_left;
   assign rsp_if.sec_left      = rsp_data_ff.sec_left;
   assign rsp_if.min_left      = rsp_data_ff.min_left;
   assign rsp_if.beat_first    = rsp_data_ff.beat_first;
   assign rsp_if.beat_second   = rsp_data_ff.beat_second;
   assign rsp_if.sample_strobe = strobe_ff;

   `MTC_ASSERT(a_done_in_mod, clock, reset, mod_done |-> (state_ff == ST_MOD), "remainder done outside its state")
   `MTC_ASSERT(a_no_overwrite, clock, reset, (rsp_valid_ff && !rsp_if.ready) |=> $stable(rsp_data_ff), "waiting word overwritten")
   `MTC_ASSERT_NEVER(a_beats_exclusive, clock, reset, rsp_valid_ff && rsp_data_ff.beat_first && rsp_data_ff.beat_second, "both heartbeat leds on")
   `MTC_ASSERT(a_strobe_tick_only, clock, reset, (commit && opcode_ff != OP_TICK) |=> !strobe_ff, "strobe on a load word")

endmodule

// ===== test/millisecond_tick_clock_tb.sv =====
// testbench for the millisecond tick clock: random tick and load words checked against a predictor
module millisecond_tick_clock_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mtc_pkg::*;

   localparam int StallLimit  = 4000;
   localparam int DrainCycles = 20;

   typedef struct packed {
      tod_state_type tod;
      logic          sample_strobe;
   } tod_reading_type;

   // tracks the time of day, the down-counters and the heartbeat, and holds the
   // readings still owed by the block
   class clock_tracker;
      logic [ValueWidth-1:0]  tick_cnt;
      logic [MsWidth-1:0]     ms_cnt;
      logic [SecWidth-1:0]    sec_cnt;
      logic [MinWidth-1:0]    min_cnt;
      logic [HourWidth-1:0]   hour_cnt;
      logic [ValueWidth-1:0]  delay_cnt;
      logic [ValueWidth-1:0]  sec_down;
      logic [ValueWidth-1:0]  min_down;
      logic                   beat_first_on;
      logic                   beat_second_on;
      logic                   sample_on;
      logic [PeriodWidth-1:0] period;
      tod_reading_type        expected_readings[$];
      int unsigned            failures;

      function new();
         tick_cnt       = '0;
         ms_cnt         = '0;
         sec_cnt        = '0;
         min_cnt        = '0;
         hour_cnt       = '0;
         delay_cnt      = '0;
         sec_down       = '0;
         min_down       = '0;
         beat_first_on  = 1'b0;
         beat_second_on = 1'b0;
         sample_on      = 1'b0;
         period         = PeriodReset;
         failures       = 0;
      endfunction

      function int unsigned pending();
         return expected_readings.size();
      endfunction

      function void note_failure(string msg);
         failures++;
         if (failures <= 10) $display("mismatch: %s", msg);
      endfunction

      function void write_reg(logic [CsrIdxWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
         case (idx)
            CSR_SAMPLE_ENABLE: sample_on = data[0];
            CSR_SAMPLE_PERIOD: period = data[PeriodWidth-1:0];
            default: ;
         endcase
      endfunction

      function void note_word(logic [OpcodeWidth-1:0] op, logic [ValueWidth-1:0] val);
         tod_reading_type want;
         int unsigned     ms_before;
         logic            strobe;
         strobe = 1'b0;
         case (op)
            OP_TICK: begin
               ms_before = 32'(ms_cnt);
               tick_cnt  = tick_cnt + 1'b1;
               if (delay_cnt != 0) delay_cnt = delay_cnt - 1'b1;
               // exactly on the first boundary both leds go dark
               beat_first_on  = (ms_before < BeatFirstEnd);
               beat_second_on = (ms_before > BeatFirstEnd) && (ms_before < BeatSecondEnd);
               if (sample_on && period != 0 && (ms_before % period) == 0) strobe = 1'b1;
               if (ms_cnt >= MsTop) begin
                  ms_cnt = '0;
                  if (sec_down != 0) sec_down = sec_down - 1'b1;
                  if (sec_cnt >= SecTop) begin
                     sec_cnt = '0;
                     if (min_down != 0) min_down = min_down - 1'b1;
                     if (min_cnt >= MinTop) begin
                        min_cnt  = '0;
                        hour_cnt = (hour_cnt >= HourTop) ? '0 : hour_cnt + 1'b1;
                     end else begin
                        min_cnt = min_cnt + 1'b1;
                     end
                  end else begin
                     sec_cnt = sec_cnt + 1'b1;
                  end
               end else begin
                  ms_cnt = ms_cnt + 1'b1;
               end
            end
            OP_LOAD_DELAY: delay_cnt = val;
            OP_LOAD_SEC:   sec_down = val;
            OP_LOAD_MIN:   min_down = val;
            default: ;
         endcase
         want.tod.tick_total  = tick_cnt;
         want.tod.millis      = ms_cnt;
         want.tod.seconds     = sec_cnt;
         want.tod.minutes     = min_cnt;
         want.tod.hours       = hour_cnt;
         want.tod.delay_left  = delay_cnt;
         want.tod.sec_left    = sec_down;
         want.tod.min_left    = min_down;
         want.tod.beat_first  = beat_first_on;
         want.tod.beat_second = beat_second_on;
         want.sample_strobe   = strobe;
         expected_readings.push_back(want);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) note_failure($sformatf("%s expected %0d got %0d", name, want, got));
      endfunction

      function void check_reading(tod_reading_type got);
         tod_reading_type want;
         if (expected_readings.size() == 0) begin
            note_failure("result word with nothing outstanding");
            return;
         end
         want = expected_readings.pop_front();
         compare_field("tick_total", want.tod.tick_total, got.tod.tick_total);
         compare_field("millis", 16'(want.tod.millis), 16'(got.tod.millis));
         compare_field("seconds", 16'(want.tod.seconds), 16'(got.tod.seconds));
         compare_field("minutes", 16'(want.tod.minutes), 16'(got.tod.minutes));
         compare_field("hours", 16'(want.tod.hours), 16'(got.tod.hours));
         compare_field("delay_left", want.tod.delay_left, got.tod.delay_left);
         compare_field("sec_left", want.tod.sec_left, got.tod.sec_left);
         compare_field("min_left", want.tod.min_left, got.tod.min_left);
         compare_field("beat_first", 16'(want.tod.beat_first), 16'(got.tod.beat_first));
         compare_field("beat_second", 16'(want.tod.beat_second), 16'(got.tod.beat_second));
         compare_field("sample_strobe", 16'(want.sample_strobe), 16'(got.sample_strobe));
      endfunction
   endclass

   logic clock;
   logic reset;

   mtc_req_if req_ch();
   mtc_rsp_if rsp_ch();
   mtc_csr_if csr_ch();

   millisecond_tick_clock DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   clock_tracker tracker = new();
   int unsigned  idle_cycles = 0;
   int unsigned  burst_left = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver ready pattern in one of four randomly picked modes
   int unsigned rsp_cyc = 0;
   int unsigned rsp_mode = 0;
   always @(posedge clock) begin
      rsp_cyc++;
      if (rsp_cyc % 256 == 0) rsp_mode = $urandom_range(0, 3);
      case (rsp_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= (rsp_cyc % 3) != 0;
         2: rsp_ch.ready <= 1'($urandom_range(0, 1));
         default: rsp_ch.ready <= (rsp_cyc % 16) < 10;
      endcase
   end

   // accepted words on all three channels, plus the stall watchdog count
   always @(posedge clock) begin
      tod_reading_type got;
      logic            moved;
      moved = 1'b0;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.tod.tick_total  = rsp_ch.tick_total;
            got.tod.millis      = rsp_ch.millis;
            got.tod.seconds     = rsp_ch.seconds;
            got.tod.minutes     = rsp_ch.minutes;
            got.tod.hours       = rsp_ch.hours;
            got.tod.delay_left  = rsp_ch.delay_left;
            got.tod.sec_left    = rsp_ch.sec_left;
            got.tod.min_left    = rsp_ch.min_left;
            got.tod.beat_first  = rsp_ch.beat_first;
            got.tod.beat_second = rsp_ch.beat_second;
            got.sample_strobe   = rsp_ch.sample_strobe;
            tracker.check_reading(got);
            moved = 1'b1;
         end
         if (req_ch.valid && req_ch.ready) begin
            tracker.note_word(req_ch.opcode, req_ch.load_value);
            moved = 1'b1;
         end
         if (csr_ch.valid && csr_ch.ready) begin
            tracker.write_reg(csr_ch.index, csr_ch.wdata);
            moved = 1'b1;
         end
         if (moved) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   initial begin
      while (idle_cycles < StallLimit) @(posedge clock);
      $display("millisecond_tick_clock test failed");
      $finish;
   end

   task automatic send_word(input logic [OpcodeWidth-1:0] op, input logic [ValueWidth-1:0] val);
      req_ch.valid      <= 1'b1;
      req_ch.opcode     <= op;
      req_ch.load_value <= val;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // a negative period leaves that register alone
   task automatic set_sampling(input logic en, input int period);
      logic [CsrDataWidth-1:0] data;
      drain_results();
      @(posedge clock);
      data    = CsrDataWidth'($urandom);
      data[0] = en;
      csr_ch.valid <= 1'b1;
      csr_ch.index <= CSR_SAMPLE_ENABLE;
      csr_ch.wdata <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      if (period >= 0) begin
         csr_ch.index <= CSR_SAMPLE_PERIOD;
         csr_ch.wdata <= period[CsrDataWidth-1:0];
         @(posedge clock);
         while (!csr_ch.ready) @(posedge clock);
      end
      csr_ch.valid <= 1'b0;
   endtask

   function automatic void pick_word(output logic [OpcodeWidth-1:0] op,
                                     output logic [ValueWidth-1:0] val);
      val = ValueWidth'($urandom);
      if ($urandom_range(0, 99) < 72) begin
         op = OP_TICK;
      end else begin
         case ($urandom_range(0, 2))
            0: op = OP_LOAD_DELAY;
            1: op = OP_LOAD_SEC;
            default: op = OP_LOAD_MIN;
         endcase
         // small loads so counters run out and sit at zero, and some all-ones loads
         case ($urandom_range(0, 3))
            0: val = ValueWidth'($urandom_range(0, 3));
            1: val = 16'hFFFF;
            default: ;
         endcase
      end
   endfunction

   task automatic send_random(input int count);
      logic [OpcodeWidth-1:0] op;
      logic [ValueWidth-1:0]  val;
      int unsigned            gap;
      for (int i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if ($urandom_range(0, 15) == 0) begin
               drain_results();
            end else if (gap != 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         pick_word(op, val);
         send_word(op, val);
      end
   endtask

   initial begin
      logic [OpcodeWidth-1:0] op;
      logic [ValueWidth-1:0]  val;
      clock             = 1'b0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.opcode     = OP_TICK;
      req_ch.load_value = '0;
      rsp_ch.ready      = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_SAMPLE_ENABLE;
      csr_ch.wdata      = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at reset settings: extremes, loads of zero, delay running out
      send_word(OP_TICK, 16'hFFFF);
      send_word(OP_LOAD_DELAY, 16'hFFFF);
      send_word(OP_LOAD_SEC, 16'hFFFF);
      send_word(OP_LOAD_MIN, 16'hFFFF);
      send_word(OP_TICK, 16'h0000);
      send_word(OP_LOAD_DELAY, 16'h0000);
      send_word(OP_LOAD_SEC, 16'h0000);
      send_word(OP_LOAD_MIN, 16'h0000);
      send_word(OP_TICK, 16'h5555);
      send_word(OP_LOAD_DELAY, 16'd2);
      send_word(OP_TICK, 16'hAAAA);
      send_word(OP_TICK, ValueWidth'($urandom));
      send_word(OP_TICK, ValueWidth'($urandom));
      send_word(OP_LOAD_SEC, 16'h5555);
      send_word(OP_LOAD_MIN, 16'hAAAA);
      // strobe on with the period still at its reset value
      set_sampling(1'b1, -1);
      repeat (4) send_word(OP_TICK, ValueWidth'($urandom));
      set_sampling(1'b1, 0);
      repeat (2) send_word(OP_TICK, ValueWidth'($urandom));
      set_sampling(1'b1, 1);
      repeat (2) send_word(OP_TICK, ValueWidth'($urandom));

      set_sampling(1'b1, PeriodReset);
      send_random(110);
      set_sampling(1'b1, 255);
      send_random(110);
      set_sampling(1'b1, 0);
      send_random(100);
      set_sampling(1'b0, 1);
      send_random(100);
      set_sampling(1'b1, 1);
      send_random(110);
      repeat (3) begin
         set_sampling(1'b1, $urandom_range(2, 254));
         send_random(95);
      end

      // short back-to-back tick run with an occasional load
      set_sampling(1'b1, 250);
      send_word(OP_LOAD_SEC, 16'd2);
      send_word(OP_LOAD_MIN, 16'd1);
      repeat (20) begin
         val = ValueWidth'($urandom);
         op  = OP_TICK;
         if ($urandom_range(0, 9) == 0) begin
            op  = $urandom_range(0, 1) ? OP_LOAD_DELAY : OP_LOAD_SEC;
            val = ValueWidth'($urandom_range(0, 5));
         end
         send_word(op, val);
      end

      drain_results();
      repeat (DrainCycles) @(posedge clock);
      if (tracker.pending() != 0)
         tracker.note_failure($sformatf("%0d results never arrived", tracker.pending()));
      if (tracker.failures == 0) begin
         $display("millisecond_tick_clock test passed");
      end else begin
         $display("millisecond_tick_clock test failed");
      end
      $finish;
   end

endmodule
